>>> rtl/epm_pkg.sv
// Shared constants, command and status types for the entropy pool mixer.
`default_nettype none

package epm_pkg;

	localparam int unsigned POOL_DEPTH = 4096;
	localparam int unsigned AW         = $clog2(POOL_DEPTH);

	localparam logic [15:0] LFSR_SEED = 16'hACE1;

	localparam logic [1:0] OP_ADD     = 2'd0;
	localparam logic [1:0] OP_MIX     = 2'd1;
	localparam logic [1:0] OP_EXTRACT = 2'd2;

	localparam int unsigned TAP1 = 511 % POOL_DEPTH;
	localparam int unsigned TAP2 = 1023 % POOL_DEPTH;
	localparam int unsigned TAP3 = 1531 % POOL_DEPTH;
	localparam int unsigned TAP4 = 2047 % POOL_DEPTH;
	localparam int unsigned TAP5 = 2557 % POOL_DEPTH;
	localparam int unsigned TAP6 = 3067 % POOL_DEPTH;
	localparam int unsigned TAP7 = 3583 % POOL_DEPTH;

	typedef struct packed {
		logic       clr_wr;
		logic       latch;
		logic       add_rd;
		logic       add_wr;
		logic       add_end;
		logic       ext_rd;
		logic       ext_acc;
		logic       ext_end;
		logic       mix_p0;
		logic       mix_p1;
		logic       mix_wr;
		logic       fin;
		logic [2:0] sel;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic bits_zero;
	} sts_t;

	function automatic logic [AW-1:0] tap_offset(input logic [2:0] k);
		logic [AW-1:0] r;
		case (k)
			3'd1:    r = AW'(TAP1);
			3'd2:    r = AW'(TAP2);
			3'd3:    r = AW'(TAP3);
			3'd4:    r = AW'(TAP4);
			3'd5:    r = AW'(TAP5);
			3'd6:    r = AW'(TAP6);
			3'd7:    r = AW'(TAP7);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/epm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module epm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/epm_ctrl.sv
// Controller state machine: sequences clear, add, mix and extract.
`default_nettype none

module epm_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [1:0]  operation,
	input  wire epm_pkg::sts_t sts,
	output epm_pkg::cmd_t    cmd,
	output logic             busy
);

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_ADD_RD  = 4'd2;
	localparam logic [3:0] S_ADD_WR  = 4'd3;
	localparam logic [3:0] S_ADD_END = 4'd4;
	localparam logic [3:0] S_EXT     = 4'd5;
	localparam logic [3:0] S_EXT_END = 4'd6;
	localparam logic [3:0] S_MIX_P0  = 4'd7;
	localparam logic [3:0] S_MIX_P1  = 4'd8;
	localparam logic [3:0] S_MIX_RUN = 4'd9;
	localparam logic [3:0] S_FIN     = 4'd10;

	logic [3:0] state_q, state_d;
	logic [2:0] cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.idx_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					cnt_d     = '0;
					unique case (operation)
						epm_pkg::OP_ADD:     state_d = S_ADD_RD;
						epm_pkg::OP_MIX:     state_d = S_MIX_P0;
						epm_pkg::OP_EXTRACT: state_d = S_EXT;
						default:             state_d = S_FIN;
					endcase
				end
			end
			S_ADD_RD: begin
				// stop once the claim is spent or four bytes are in
				if (sts.bits_zero || cnt_q == 3'd4) begin
					state_d = S_ADD_END;
				end else begin
					cmd.add_rd = 1'b1;
					state_d    = S_ADD_WR;
				end
			end
			S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				cnt_d      = cnt_q + 3'd1;
				state_d    = S_ADD_RD;
			end
			S_ADD_END: begin
				cmd.add_end = 1'b1;
				state_d     = S_FIN;
			end
			S_EXT: begin
				cmd.ext_rd  = 1'b1;
				cmd.sel     = cnt_q;
				cmd.ext_acc = (cnt_q != 3'd0);
				cnt_d       = cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					state_d = S_EXT_END;
				end
			end
			S_EXT_END: begin
				cmd.ext_acc = 1'b1;
				cmd.ext_end = 1'b1;
				state_d     = S_FIN;
			end
			S_MIX_P0: begin
				cmd.mix_p0 = 1'b1;
				state_d    = S_MIX_P1;
			end
			S_MIX_P1: begin
				cmd.mix_p1 = 1'b1;
				state_d    = S_MIX_RUN;
			end
			S_MIX_RUN: begin
				cmd.mix_wr = 1'b1;
				if (sts.idx_last) begin
					cnt_d = cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						state_d = S_FIN;
					end else begin
						state_d = S_MIX_P0;
					end
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/epm_datapath.sv
// Datapath: pool RAM, pointer, LFSR, counters and result registers.
`default_nettype none

module epm_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire epm_pkg::cmd_t cmd,
	input  wire logic [31:0]   entropy_word,
	input  wire logic [7:0]    entropy_bits,
	output epm_pkg::sts_t      sts,
	output logic               done,
	output logic [7:0]         random_byte,
	output logic [7:0]         leftover_bits,
	output logic [31:0]        sample_total,
	output logic [31:0]        byte_total
);

	localparam int unsigned AW = epm_pkg::AW;
	localparam logic [AW-1:0] LAST = AW'(epm_pkg::POOL_DEPTH - 1);

	logic [AW-1:0] ptr_q, idx_q, rdx_q;
	logic [31:0]   word_q;
	logic [7:0]    bits_q;
	logic [7:0]    acc_q;
	logic [15:0]   lfsr_q, lfsr_nxt;
	logic [7:0]    cur_q, prev_q;
	logic [31:0]   sample_q, byte_q;
	logic [7:0]    leftover_q;
	logic          done_q;
	logic [7:0]    rb_q;
	logic [31:0]   st_q, bt_q;
	logic [7:0]    lo_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;
	logic [AW:0]   ext_sum;
	logic [AW-1:0] ext_addr;
	logic [AW-1:0] ptr_nxt, idx_nxt;
	logic [7:0]    mix_val, nbr;

	epm_ram #(
		.WIDTH(8),
		.DEPTH(epm_pkg::POOL_DEPTH)
	) u_pool (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign ptr_nxt  = (ptr_q == LAST) ? '0 : ptr_q + AW'(1);
	assign idx_nxt  = (idx_q == LAST) ? '0 : idx_q + AW'(1);
	assign ext_sum  = {1'b0, ptr_q} + {1'b0, epm_pkg::tap_offset(cmd.sel)};
	assign ext_addr = (ext_sum >= (AW+1)'(epm_pkg::POOL_DEPTH))
		? AW'(ext_sum - (AW+1)'(epm_pkg::POOL_DEPTH)) : ext_sum[AW-1:0];

	assign lfsr_nxt = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
	// the last entry has no right neighbor
	assign nbr      = (idx_q == LAST) ? 8'h00 : {1'b0, rdata[7:1]};
	assign mix_val  = cur_q ^ lfsr_nxt[7:0] ^ prev_q ^ nbr;

	always_comb begin
		raddr = '0;
		if (cmd.add_rd) begin
			raddr = ptr_q;
		end else if (cmd.ext_rd) begin
			raddr = ext_addr;
		end else if (cmd.mix_p1 || cmd.mix_wr) begin
			raddr = rdx_q;
		end
	end

	assign we    = cmd.clr_wr | cmd.add_wr | cmd.mix_wr;
	assign waddr = cmd.add_wr ? ptr_q : idx_q;

	always_comb begin
		wdata = 8'h00;
		if (cmd.add_wr) begin
			wdata = rdata ^ word_q[7:0];
		end else if (cmd.mix_wr) begin
			wdata = mix_val;
		end
	end

	assign sts.idx_last  = (idx_q == LAST);
	assign sts.bits_zero = (bits_q == 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			idx_q      <= '0;
			rdx_q      <= '0;
			sample_q   <= '0;
			byte_q     <= '0;
			leftover_q <= '0;
			done_q     <= 1'b0;
			rb_q       <= '0;
			st_q       <= '0;
			bt_q       <= '0;
			lo_q       <= '0;
		end else begin
			done_q <= cmd.fin;
			if (cmd.clr_wr || cmd.mix_wr) begin
				idx_q <= idx_nxt;
			end else if (cmd.mix_p0) begin
				idx_q <= '0;
			end
			if (cmd.mix_p0) begin
				rdx_q <= AW'(1);
			end else if (cmd.mix_p1 || cmd.mix_wr) begin
				// hold at the last entry; reads past it are not used
				rdx_q <= (rdx_q == LAST) ? rdx_q : rdx_q + AW'(1);
			end
			if (cmd.add_wr || cmd.ext_end) begin
				ptr_q <= ptr_nxt;
			end
			if (cmd.add_end) begin
				sample_q   <= sample_q + 32'd1;
				leftover_q <= bits_q;
			end
			if (cmd.ext_end) begin
				byte_q <= byte_q + 32'd1;
			end
			if (cmd.fin) begin
				rb_q <= acc_q;
				st_q <= sample_q;
				bt_q <= byte_q;
				lo_q <= leftover_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			word_q <= entropy_word;
			bits_q <= entropy_bits;
			acc_q  <= 8'h00;
			lfsr_q <= epm_pkg::LFSR_SEED;
		end else begin
			if (cmd.add_wr) begin
				word_q <= {8'h00, word_q[31:8]};
				bits_q <= (bits_q > 8'd8) ? bits_q - 8'd8 : 8'd0;
			end
			if (cmd.ext_acc) begin
				acc_q <= acc_q ^ rdata;
			end
			if (cmd.mix_wr) begin
				lfsr_q <= lfsr_nxt;
			end
		end
		if (cmd.mix_p1) begin
			cur_q  <= rdata;
			prev_q <= 8'h00;
		end else if (cmd.mix_wr) begin
			cur_q  <= rdata;
			prev_q <= mix_val;
		end
	end

	assign done          = done_q;
	assign random_byte   = rb_q;
	assign leftover_bits = lo_q;
	assign sample_total  = st_q;
	assign byte_total    = bt_q;

endmodule

`default_nettype wire

>>> rtl/entropy_pool_mixer.sv
// Top level of the entropy pool mixer: controller, datapath and checks.
//
// Channel   Direction  Handshake              Words
// command   in         start, busy            operation, entropy_word, entropy_bits
// result    out        done (one-cycle pulse) random_byte, leftover_bits,
//                                             sample_total, byte_total
//
// Add writes one pool entry per byte used (up to four), extract XORs eight pool
// entries at fixed taps, mix makes four passes over the pool, an unused code goes
// straight to the result. The single read port of the pool RAM allows one entry
// access per cycle. After reset a clearing pass writes zero to every pool entry
// with busy high. The result register frees the command side: a new word is taken
// in the cycle done is shown. The receiver cannot stall; done lasts one cycle.
`default_nettype none

module entropy_pool_mixer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] entropy_word,
	input  wire logic [7:0]  entropy_bits,
	output logic             done,
	output logic [7:0]       random_byte,
	output logic [7:0]       leftover_bits,
	output logic [31:0]      sample_total,
	output logic [31:0]      byte_total
);

	epm_pkg::cmd_t cmd;
	epm_pkg::sts_t sts;

	epm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(operation),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	epm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.entropy_word (entropy_word),
		.entropy_bits (entropy_bits),
		.sts          (sts),
		.done         (done),
		.random_byte  (random_byte),
		.leftover_bits(leftover_bits),
		.sample_total (sample_total),
		.byte_total   (byte_total)
	);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> ($stable(sample_total) && $stable(byte_total)
			&& $stable(leftover_bits)))
		else $error("result word changed without done");
`endif

endmodule

`default_nettype wire
